FILE: hdl/mcg_pkg.sv
// ----------------------------------------------------------------------------
// mcg_pkg
// Shared types, widths and calendar tables of the month calendar grid.
// ----------------------------------------------------------------------------
package mcg_pkg;

  localparam int unsigned IdxW     = 17;
  localparam int unsigned YearCfgW = 15;
  localparam int unsigned YearW    = 14;
  localparam int unsigned MonthW   = 4;
  localparam int unsigned DayW     = 5;
  localparam int unsigned PosW     = 6;
  localparam int unsigned CfgIdxW  = 2;

  localparam int unsigned DivW       = 17;
  localparam int unsigned DvsW       = 7;
  localparam int unsigned RecipW     = 16;
  localparam int unsigned RecipShift = 17;

  localparam logic [DvsW-1:0] DVS_MONTHS  = DvsW'(12);
  localparam logic [DvsW-1:0] DVS_CENTURY = DvsW'(100);
  localparam logic [DvsW-1:0] DVS_WEEK    = DvsW'(7);

  // scaled by 2^17, applied after a shift by two for months and centuries
  localparam logic [RecipW-1:0] RECIP_MONTHS  = RecipW'(43691);
  localparam logic [RecipW-1:0] RECIP_CENTURY = RecipW'(5243);
  localparam logic [RecipW-1:0] RECIP_WEEK    = RecipW'(18725);

  localparam logic [15:0] YEAR_MAX = 16'd9999;

  localparam logic [CfgIdxW-1:0] CFG_FIRST_YEAR = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] CFG_LAST_YEAR  = CfgIdxW'(1);

  typedef struct packed {
    logic [YearW-1:0]  year;
    logic [MonthW-1:0] month;
    logic [2:0]        lead;
    logic [DayW-1:0]   len;
    logic [DayW-1:0]   plen;
  } mcg_grid_t;

  function automatic logic [DayW-1:0] month_days(input logic [MonthW-1:0] m);
    logic [DayW-1:0] d;
    case (m)
      4'd2:                      d = 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:   d = 5'd30;
      default:                   d = 5'd31;
    endcase
    return d;
  endfunction

  function automatic logic [2:0] dow_offset(input logic [MonthW-1:0] m);
    logic [2:0] o;
    case (m)
      4'd2:    o = 3'd3;
      4'd3:    o = 3'd2;
      4'd4:    o = 3'd5;
      4'd5:    o = 3'd0;
      4'd6:    o = 3'd3;
      4'd7:    o = 3'd5;
      4'd8:    o = 3'd1;
      4'd9:    o = 3'd4;
      4'd10:   o = 3'd6;
      4'd11:   o = 3'd2;
      4'd12:   o = 3'd4;
      default: o = 3'd0;
    endcase
    return o;
  endfunction

endpackage

FILE: hdl/month_calendar_grid.sv
// ----------------------------------------------------------------------------
// month_calendar_grid
// Monday-first Gregorian grid of one month, one cell per output request.
// A request names a month counted from January of first_year. The block
// checks it against the configured year range, then runs three divisions on
// one shared reciprocal-multiply divider (month index by 12, year by 100,
// weekday sum by 7) and emits 28 to 42 cells, one per cycle while the
// output is not stalled. The input is free again the cycle after the
// last cell is taken. A request that is out of range, or whose year
// exceeds 9999, yields no cells and frees the input.
// The input stays stalled until the last cell has been taken.
// ----------------------------------------------------------------------------
module month_calendar_grid
  import mcg_pkg::*;
(
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic [CfgIdxW-1:0]        cfg_index_i,
  input  logic [YearCfgW-1:0]       cfg_data_i,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic [IdxW-1:0]           month_index_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic [DayW-1:0]           day_number_o,
  output logic                      in_month_o,
  output logic [YearW-1:0]          grid_year_o,
  output logic [MonthW-1:0]         grid_month_o,
  output logic [PosW-1:0]           cell_position_o,
  output logic                      last_cell_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_DIV12,
    ST_DIV100,
    ST_DIV7,
    ST_EMIT
  } state_e;

  state_e                      state_q;
  logic signed [YearCfgW-1:0]  first_q;
  logic signed [YearCfgW-1:0]  last_q;
  logic [IdxW-1:0]             idx_q;
  logic [YearW-1:0]            year_q;
  logic [MonthW-1:0]           month_q;
  logic                        leap_q;

  logic                        div_start_q;
  logic [DivW-1:0]             div_dividend_q;
  logic [DvsW-1:0]             div_divisor_q;
  logic                        div_done;
  logic [DivW-1:0]             div_quot;
  logic [DvsW-1:0]             div_rem;

  logic                        gen_start_q;
  mcg_grid_t                   grid_q;
  logic                        gen_done;

  logic signed [16:0]          diff;
  logic [18:0]                 span;
  logic                        req_ok;
  logic [15:0]                 year_sum;
  logic [MonthW-1:0]           month_d;
  logic                        early;
  logic                        leap_d;
  logic [YearW-1:0]            yy;
  logic [6:0]                  qy;
  logic [14:0]                 wd_sum;
  logic [2:0]                  lead_d;
  logic [DayW-1:0]             len_d;
  logic [DayW-1:0]             plen_d;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = (state_q != ST_IDLE);

  always_comb begin
    diff   = {{2{last_q[YearCfgW-1]}}, last_q} - {{2{first_q[YearCfgW-1]}}, first_q}
             + 17'sd1;
    span   = {diff[15:0], 3'b000} + {1'b0, diff[15:0], 2'b00};
    req_ok = (last_q > first_q) && (first_q >= 15'sd1) && ({2'b00, idx_q} < span);

    year_sum = {2'b00, first_q[13:0]} + {2'b00, div_quot[13:0]};
    month_d  = div_rem[3:0] + 4'd1;

    early  = (month_q < 4'd3);
    leap_d = (year_q[1:0] == 2'b00) &&
             ((div_rem != '0) || (div_quot[1:0] == 2'b00));
    yy     = early ? year_q - 14'd1 : year_q;
    qy     = (early && (div_rem == '0)) ? div_quot[6:0] - 7'd1 : div_quot[6:0];
    wd_sum = {1'b0, yy} + {3'b000, yy[13:2]} - {8'd0, qy} + {10'd0, qy[6:2]}
             + {12'd0, dow_offset(month_q)} + 15'd1;

    lead_d = (div_rem[2:0] == 3'd0) ? 3'd6 : div_rem[2:0] - 3'd1;
    len_d  = ((month_q == 4'd2) && leap_q) ? 5'd29 : month_days(month_q);
    if (month_q == 4'd1) begin
      plen_d = 5'd31;
    end else if ((month_q == 4'd3) && leap_q) begin
      plen_d = 5'd29;
    end else begin
      plen_d = month_days(month_q - 4'd1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_q <= -15'sd1;
      last_q  <= -15'sd1;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CFG_FIRST_YEAR: first_q <= cfg_data_i;
        CFG_LAST_YEAR:  last_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      div_start_q <= 1'b0;
      gen_start_q <= 1'b0;
    end else begin
      div_start_q <= 1'b0;
      gen_start_q <= 1'b0;
      unique case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            idx_q   <= month_index_i;
            state_q <= ST_CHECK;
          end
        end
        ST_CHECK: begin
          if (req_ok) begin
            div_start_q    <= 1'b1;
            div_dividend_q <= idx_q;
            div_divisor_q  <= DVS_MONTHS;
            state_q        <= ST_DIV12;
          end else begin
            state_q <= ST_IDLE;
          end
        end
        ST_DIV12: begin
          if (div_done) begin
            if (year_sum > YEAR_MAX) begin
              state_q <= ST_IDLE;
            end else begin
              year_q         <= year_sum[13:0];
              month_q        <= month_d;
              div_start_q    <= 1'b1;
              div_dividend_q <= {3'b000, year_sum[13:0]};
              div_divisor_q  <= DVS_CENTURY;
              state_q        <= ST_DIV100;
            end
          end
        end
        ST_DIV100: begin
          if (div_done) begin
            leap_q         <= leap_d;
            div_start_q    <= 1'b1;
            div_dividend_q <= {2'b00, wd_sum};
            div_divisor_q  <= DVS_WEEK;
            state_q        <= ST_DIV7;
          end
        end
        ST_DIV7: begin
          if (div_done) begin
            grid_q.year  <= year_q;
            grid_q.month <= month_q;
            grid_q.lead  <= lead_d;
            grid_q.len   <= len_d;
            grid_q.plen  <= plen_d;
            gen_start_q  <= 1'b1;
            state_q      <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (gen_done) begin
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  mcg_divider u_divider (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start_q),
    .dividend_i (div_dividend_q),
    .divisor_i  (div_divisor_q),
    .done_o     (div_done),
    .quot_o     (div_quot),
    .rem_o      (div_rem)
  );

  mcg_cell_gen u_cell_gen (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start_i         (gen_start_q),
    .grid_i          (grid_q),
    .done_o          (gen_done),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .day_number_o    (day_number_o),
    .in_month_o      (in_month_o),
    .grid_year_o     (grid_year_o),
    .grid_month_o    (grid_month_o),
    .cell_position_o (cell_position_o),
    .last_cell_o     (last_cell_o)
  );

endmodule

FILE: hdl/mcg_divider.sv
// ----------------------------------------------------------------------------
// mcg_divider
// Shared constant divider: reciprocal multiply for the quotient, then
// multiply back and subtract for the remainder.
// ----------------------------------------------------------------------------
module mcg_divider
  import mcg_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic [DivW-1:0]     dividend_i,
  input  logic [DvsW-1:0]     divisor_i,
  output logic                done_o,
  output logic [DivW-1:0]     quot_o,
  output logic [DvsW-1:0]     rem_o
);

  logic [DivW-1:0]        dividend_q;
  logic [DvsW-1:0]        divisor_q;
  logic [DivW-1:0]        quot_q;
  logic [DvsW-1:0]        rem_q;
  logic                   busy_q;
  logic                   done_q;

  logic [DivW-1:0]        scaled;
  logic [RecipW-1:0]      recip;
  logic [DivW+RecipW-1:0] product;
  logic [DivW-1:0]        quot_d;
  logic [DivW+DvsW-1:0]   back;
  logic [DivW-1:0]        rem_full;
  logic [DvsW-1:0]        rem_d;

  always_comb begin
    unique case (divisor_i)
      DVS_MONTHS: begin
        scaled = dividend_i >> 2;
        recip  = RECIP_MONTHS;
      end
      DVS_CENTURY: begin
        scaled = dividend_i >> 2;
        recip  = RECIP_CENTURY;
      end
      DVS_WEEK: begin
        scaled = dividend_i;
        recip  = RECIP_WEEK;
      end
      default: begin
        scaled = dividend_i;
        recip  = RECIP_WEEK;
      end
    endcase
    product  = {{RecipW{1'b0}}, scaled} * {{DivW{1'b0}}, recip};
    quot_d   = DivW'(product[DivW+RecipW-1:RecipShift]);
    back     = {{DvsW{1'b0}}, quot_q} * {{DivW{1'b0}}, divisor_q};
    rem_full = dividend_q - back[DivW-1:0];
    rem_d    = rem_full[DvsW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      busy_q <= start_i;
      done_q <= busy_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dividend_q <= dividend_i;
      divisor_q  <= divisor_i;
      quot_q     <= quot_d;
    end else if (busy_q) begin
      rem_q <= rem_d;
    end
  end

  assign done_o = done_q;
  assign quot_o = quot_q;
  assign rem_o  = rem_q;

endmodule

FILE: hdl/mcg_cell_gen.sv
// ----------------------------------------------------------------------------
// mcg_cell_gen
// Walks the grid cells of one month and drives the registered output.
// ----------------------------------------------------------------------------
module mcg_cell_gen
  import mcg_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  mcg_grid_t          grid_i,
  output logic               done_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [DayW-1:0]    day_number_o,
  output logic               in_month_o,
  output logic [YearW-1:0]   grid_year_o,
  output logic [MonthW-1:0]  grid_month_o,
  output logic [PosW-1:0]    cell_position_o,
  output logic               last_cell_o
);

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_PREV,
    PH_CUR,
    PH_NEXT
  } phase_e;

  phase_e           phase_q;
  mcg_grid_t        grid_q;
  logic [DayW-1:0]  day_q;
  logic [2:0]       col_q;
  logic [PosW-1:0]  pos_q;

  logic             out_valid_q;
  logic [DayW-1:0]  day_number_q;
  logic             in_month_q;
  logic [PosW-1:0]  cell_position_q;
  logic             last_cell_q;

  logic             free;
  logic             is_last;
  logic [DayW-1:0]  day_init;

  always_comb begin
    free     = !out_valid_q || !out_stall_i;
    is_last  = (col_q == 3'd6) &&
               ((phase_q == PH_NEXT) || ((phase_q == PH_CUR) && (day_q == grid_q.len)));
    day_init = DayW'({1'b0, grid_i.plen} + 6'd1 - {3'b0, grid_i.lead});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      if (free) begin
        out_valid_q <= 1'b0;
      end
      if (start_i) begin
        grid_q <= grid_i;
        col_q  <= '0;
        pos_q  <= '0;
        if (grid_i.lead == 3'd0) begin
          phase_q <= PH_CUR;
          day_q   <= DayW'(1);
        end else begin
          phase_q <= PH_PREV;
          day_q   <= day_init;
        end
      end else if (free && (phase_q != PH_IDLE)) begin
        out_valid_q     <= 1'b1;
        day_number_q    <= day_q;
        in_month_q      <= (phase_q == PH_CUR);
        cell_position_q <= pos_q;
        last_cell_q     <= is_last;
        pos_q           <= pos_q + PosW'(1);
        col_q           <= (col_q == 3'd6) ? 3'd0 : col_q + 3'd1;
        day_q           <= day_q + DayW'(1);
        unique case (phase_q)
          PH_PREV: begin
            if (day_q == grid_q.plen) begin
              phase_q <= PH_CUR;
              day_q   <= DayW'(1);
            end
          end
          PH_CUR: begin
            if (is_last) begin
              phase_q <= PH_IDLE;
            end else if (day_q == grid_q.len) begin
              phase_q <= PH_NEXT;
              day_q   <= DayW'(1);
            end
          end
          PH_NEXT: begin
            if (is_last) begin
              phase_q <= PH_IDLE;
            end
          end
          default: begin
            phase_q <= PH_IDLE;
          end
        endcase
      end
    end
  end

  assign done_o          = out_valid_q && !out_stall_i && last_cell_q;
  assign out_valid_o     = out_valid_q;
  assign day_number_o    = day_number_q;
  assign in_month_o      = in_month_q;
  assign grid_year_o     = grid_q.year;
  assign grid_month_o    = grid_q.month;
  assign cell_position_o = cell_position_q;
  assign last_cell_o     = last_cell_q;

endmodule
